### design/i2cls_pkg.sv
`timescale 1ns / 1ps

package i2cls_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int PHASE_W       = 6;
  localparam int KIND_W        = 3;

  localparam logic [KIND_W-1:0] K_START = 3'd0;
  localparam logic [KIND_W-1:0] K_STOP  = 3'd1;
  localparam logic [KIND_W-1:0] K_WRITE = 3'd2;
  localparam logic [KIND_W-1:0] K_READ  = 3'd3;
  localparam logic [KIND_W-1:0] K_ACK   = 3'd4;

  // command lengths in ticks
  localparam logic [PHASE_W-1:0] LEN_START = PHASE_W'(4);
  localparam logic [PHASE_W-1:0] LEN_STOP  = PHASE_W'(3);
  localparam logic [PHASE_W-1:0] LEN_WRITE = PHASE_W'(2 * BITS_PER_BYTE + 4);
  localparam logic [PHASE_W-1:0] LEN_READ  = PHASE_W'(4 * BITS_PER_BYTE + 2);
  localparam logic [PHASE_W-1:0] LEN_ACK   = PHASE_W'(3);

  // phase landmarks
  localparam logic [PHASE_W-1:0] PH_WR_ACK  = PHASE_W'(2 * BITS_PER_BYTE);
  localparam logic [PHASE_W-1:0] PH_RD_TAIL = PHASE_W'(4 * BITS_PER_BYTE);

  typedef struct packed {
    logic                     cmd_valid;
    logic [KIND_W-1:0]        kind;
    logic [BITS_PER_BYTE-1:0] tx_byte;
    logic                     ack_level;
    logic                     sda_in;
  } in_t;

  typedef struct packed {
    logic                     scl_out;
    logic                     sda_out;
    logic                     busy_res;
    logic                     done_res;
    logic [BITS_PER_BYTE-1:0] rx_byte;
    logic                     ack_seen;
  } out_t;

  typedef struct packed {
    logic [PHASE_W-1:0]       phase;
    logic [KIND_W-1:0]        kind;
    logic                     busy;
    logic [BITS_PER_BYTE-1:0] shreg;
    logic                     scl;
    logic                     sda;
    logic                     ack;
  } seq_state_t;

  function automatic logic [PHASE_W-1:0] cmd_len(input logic [KIND_W-1:0] k);
    logic [PHASE_W-1:0] len;
    case (k)
      K_START: len = LEN_START;
      K_STOP:  len = LEN_STOP;
      K_WRITE: len = LEN_WRITE;
      K_READ:  len = LEN_READ;
      default: len = LEN_ACK;
    endcase
    return len;
  endfunction

endpackage

### design/i2cls_step.sv
`timescale 1ns / 1ps

module i2cls_step import i2cls_pkg::*; (
  input  seq_state_t st,
  input  in_t        item,
  output seq_state_t st_nxt,
  output out_t       res
);

  seq_state_t         w;
  logic               take;
  logic               done;
  logic [PHASE_W-1:0] p;

  always_comb begin
    w    = st;
    res  = '0;
    done = 1'b0;
    take = !st.busy && item.cmd_valid &&
           (item.kind inside {K_START, K_STOP, K_WRITE, K_READ, K_ACK});
    if (take) begin
      w.busy  = 1'b1;
      w.kind  = item.kind;
      w.phase = '0;
      w.ack   = 1'b0;
      w.shreg = (item.kind == K_WRITE) ? item.tx_byte : '0;
    end
    p = w.phase;

    if (!w.busy) begin
      // idle tick: lines hold
      res.scl_out = st.scl;
      res.sda_out = st.sda;
    end else begin
      case (w.kind)
        K_START: begin
          if (p == PHASE_W'(0))      w.sda = 1'b1;
          else if (p == PHASE_W'(1)) w.scl = 1'b1;
          else if (p == PHASE_W'(2)) w.sda = 1'b0;
          else                       w.scl = 1'b0;
        end
        K_STOP: begin
          if (p == PHASE_W'(0))      w.sda = 1'b0;
          else if (p == PHASE_W'(1)) w.scl = 1'b1;
          else                       w.sda = 1'b1;
        end
        K_WRITE: begin
          if (p < PH_WR_ACK) begin
            if (!p[0]) begin
              w.sda = w.shreg[BITS_PER_BYTE-1];
              if (p != '0) w.scl = 1'b0;
            end else begin
              w.scl   = 1'b1;
              w.shreg = {w.shreg[BITS_PER_BYTE-2:0], 1'b0};
            end
          end else if (p == PH_WR_ACK) begin
            w.scl = 1'b0;
          end else if (p == PH_WR_ACK + PHASE_W'(1)) begin
            w.sda = 1'b1;
          end else if (p == PH_WR_ACK + PHASE_W'(2)) begin
            w.scl = 1'b1;
            w.ack = !item.sda_in;
          end else begin
            w.scl = 1'b0;
          end
        end
        K_READ: begin
          w.sda = 1'b1;
          if (p < PH_RD_TAIL) begin
            case (p[1:0])
              2'd1: w.scl = 1'b0;
              2'd2: begin
                w.scl   = 1'b1;
                w.shreg = {w.shreg[BITS_PER_BYTE-2:0], item.sda_in};
              end
              2'd3: w.scl = 1'b1;
              default: ;
            endcase
          end else begin
            w.scl = 1'b0;
          end
        end
        default: begin
          if (p == PHASE_W'(0))      w.sda = item.ack_level;
          else if (p == PHASE_W'(1)) w.scl = 1'b1;
          else                       w.scl = 1'b0;
        end
      endcase

      done = (p + PHASE_W'(1)) >= cmd_len(w.kind);
      res.scl_out  = w.scl;
      res.sda_out  = w.sda;
      res.busy_res = 1'b1;
      res.done_res = done;
      res.rx_byte  = (done && w.kind == K_READ) ? w.shreg : '0;
      res.ack_seen = done && (w.kind == K_WRITE) && w.ack;
      if (done) begin
        w.busy  = 1'b0;
        w.phase = '0;
      end else begin
        w.phase = p + PHASE_W'(1);
      end
    end
    st_nxt = w;
  end

endmodule

### design/i2c_master_line_sequencer.sv
`timescale 1ns / 1ps

// Bit-level I2C master sequencer. Each input transaction is one bus delay tick: it carries
// the sampled SDA level and, while the sequencer is idle, an optional command (start 4 ticks,
// stop 3, write byte 20, read byte 34, ack/nack bit 3). Every tick gives one result with the
// SCL and SDA levels to drive, busy and done; at done a read returns rx_byte and a write
// returns ack_seen. One tick is taken per clock while in_stall is low: the line state is
// updated by a single pass of logic into the state registers, and results leave through an
// output register backed by a one-entry skid buffer, so in_stall only rises when both are
// full. A result is registered in the output register, or in the skid buffer if it is held.

module i2c_master_line_sequencer import i2cls_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  seq_state_t st_r, st_nxt;
  out_t       res;
  out_t       out_data_r, out_data_nxt;
  out_t       skid_data_r, skid_data_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  logic       accept;
  logic       out_free;

  i2cls_step u_step (
    .st     (st_r),
    .item   (in_data),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (accept) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // lines released after reset
      st_r         <= '{phase: '0, kind: K_START, busy: 1'b0, shreg: '0,
                        scl: 1'b1, sda: 1'b1, ack: 1'b0};
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) st_r <= st_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // skid entry only ever sits behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid buffer full with output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid buffer filled without a stalled output");

  a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.busy |-> (st_r.phase < cmd_len(st_r.kind)))
    else $error("phase ran past the end of the command");

  a_idle_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.busy |-> (st_r.phase == '0))
    else $error("idle sequencer holds a nonzero phase");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.done_res) |=> !st_r.busy)
    else $error("sequencer still busy after the last tick of a command");

endmodule

### tb/sv/i2c_master_line_sequencer_tb.sv
`timescale 1ns / 1ps

module i2c_master_line_sequencer_tb;
  import i2cls_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WR_ACK_TICK = 2 * BITS_PER_BYTE + 2;
  localparam int RD_BIT_TICKS = 4 * BITS_PER_BYTE;
  localparam logic [KIND_W-1:0] K_UNUSED_LO = K_ACK + 1'b1;
  localparam logic [KIND_W-1:0] K_UNUSED_HI = '1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  // predicted sequencer state
  logic [PHASE_W-1:0]       ln_phase;
  logic [KIND_W-1:0]        ln_kind;
  logic                     ln_busy;
  logic [BITS_PER_BYTE-1:0] ln_shift;
  logic                     ln_scl;
  logic                     ln_sda;
  logic                     ln_ack;

  out_t expected_lines[$];
  out_t want;
  int   fails;
  int   cycles;
  int   ticks_sent;
  int   busy_ticks;
  int   cmds_taken[K_ACK+1];
  bit   quiet_run;

  i2c_master_line_sequencer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [PHASE_W-1:0] ticks_for(input logic [KIND_W-1:0] k);
    case (k)
      K_START: return PHASE_W'(4);
      K_STOP:  return PHASE_W'(3);
      K_WRITE: return PHASE_W'(2 * BITS_PER_BYTE + 4);
      K_READ:  return PHASE_W'(4 * BITS_PER_BYTE + 2);
      default: return PHASE_W'(3);
    endcase
  endfunction

  // advances the predicted sequencer by one tick and gives the line levels it drives
  function automatic out_t line_tick(input in_t t);
    out_t r;
    logic [PHASE_W-1:0] p;
    logic scl;
    logic sda;
    r = '0;
    if (!ln_busy) begin
      if (t.cmd_valid && t.kind <= K_ACK) begin
        ln_busy  = 1'b1;
        ln_kind  = t.kind;
        ln_phase = '0;
        ln_ack   = 1'b0;
        ln_shift = (t.kind == K_WRITE) ? t.tx_byte : '0;
      end else begin
        r.scl_out = ln_scl;
        r.sda_out = ln_sda;
        return r;
      end
    end
    p   = ln_phase;
    scl = ln_scl;
    sda = ln_sda;
    case (ln_kind)
      K_START: begin
        if (p == 0) sda = 1'b1;
        else if (p == 1) scl = 1'b1;
        else if (p == 2) sda = 1'b0;
        else scl = 1'b0;
      end
      K_STOP: begin
        if (p == 0) sda = 1'b0;
        else if (p == 1) scl = 1'b1;
        else sda = 1'b1;
      end
      K_WRITE: begin
        if (p < 2 * BITS_PER_BYTE) begin
          if (!p[0]) begin
            sda = ln_shift[BITS_PER_BYTE-1];
            if (p != 0) scl = 1'b0;
          end else begin
            scl = 1'b1;
            ln_shift = {ln_shift[BITS_PER_BYTE-2:0], 1'b0};
          end
        end else if (p == 2 * BITS_PER_BYTE) begin
          scl = 1'b0;
        end else if (p == 2 * BITS_PER_BYTE + 1) begin
          sda = 1'b1;
        end else if (p == WR_ACK_TICK) begin
          scl = 1'b1;
          ln_ack = ~t.sda_in;
        end else begin
          scl = 1'b0;
        end
      end
      K_READ: begin
        sda = 1'b1;
        if (p < RD_BIT_TICKS) begin
          case (p[1:0])
            2'd1: scl = 1'b0;
            2'd2: begin
              scl = 1'b1;
              ln_shift = {ln_shift[BITS_PER_BYTE-2:0], t.sda_in};
            end
            2'd3: scl = 1'b1;
            default: ;
          endcase
        end else begin
          scl = 1'b0;
        end
      end
      default: begin
        if (p == 0) sda = t.ack_level;
        else if (p == 1) scl = 1'b1;
        else scl = 1'b0;
      end
    endcase
    ln_scl = scl;
    ln_sda = sda;
    r.scl_out  = scl;
    r.sda_out  = sda;
    r.busy_res = 1'b1;
    if (p + 1 >= ticks_for(ln_kind)) begin
      r.done_res = 1'b1;
      if (ln_kind == K_READ) r.rx_byte = ln_shift;
      if (ln_kind == K_WRITE) r.ack_seen = ln_ack;
      ln_busy  = 1'b0;
      ln_phase = '0;
    end else begin
      ln_phase = p + 1'b1;
    end
    return r;
  endfunction

  task automatic send_tick(input in_t item);
    out_t r;
    bit was_idle;
    if (!quiet_run && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    was_idle = !ln_busy;
    r = line_tick(item);
    expected_lines.push_back(r);
    ticks_sent++;
    if (r.busy_res) busy_ticks++;
    if (was_idle && r.busy_res) cmds_taken[item.kind]++;
  endtask

  // offers one command, then clocks it through with random commands offered while busy
  task automatic issue_command(input logic [KIND_W-1:0] k, input logic [7:0] tx,
                               input logic ackl, input logic [7:0] slave_bits,
                               input logic ack_line);
    in_t t;
    t.cmd_valid = 1'b1;
    t.kind      = k;
    t.tx_byte   = tx;
    t.ack_level = ackl;
    t.sda_in    = (k == K_READ) ? slave_bits[BITS_PER_BYTE-1] : 1'($urandom);
    send_tick(t);
    while (ln_busy) begin
      t = in_t'($urandom);
      if (ln_kind == K_READ && ln_phase < RD_BIT_TICKS)
        t.sda_in = slave_bits[BITS_PER_BYTE-1-ln_phase/4];
      else if (ln_kind == K_WRITE && ln_phase == WR_ACK_TICK)
        t.sda_in = ack_line;
      send_tick(t);
    end
  endtask

  task automatic send_idle_tick(input bit bad_kind);
    in_t t;
    t = in_t'($urandom);
    t.cmd_valid = bad_kind;
    if (bad_kind) t.kind = KIND_W'($urandom_range(K_UNUSED_LO, K_UNUSED_HI));
    send_tick(t);
  endtask

  task automatic test_idle_after_reset();
    send_idle_tick(1'b0);
    send_idle_tick(1'b1);
    send_idle_tick(1'b0);
  endtask

  task automatic test_bus_conditions();
    issue_command(K_START, 8'h00, 1'b0, 8'h00, 1'b1);
    issue_command(K_STOP, 8'hFF, 1'b1, 8'hFF, 1'b0);
    issue_command(K_START, 8'h00, 1'b1, 8'h00, 1'b0);
  endtask

  task automatic test_byte_write();
    issue_command(K_WRITE, 8'hFF, 1'b0, 8'h00, 1'b1);
    issue_command(K_WRITE, 8'h00, 1'b1, 8'hFF, 1'b0);
    issue_command(K_WRITE, 8'h96, 1'b0, 8'h00, 1'b0);
    issue_command(K_WRITE, 8'h69, 1'b1, 8'hFF, 1'b1);
  endtask

  task automatic test_byte_read();
    issue_command(K_READ, 8'h00, 1'b0, 8'hFF, 1'b0);
    issue_command(K_READ, 8'hFF, 1'b1, 8'h00, 1'b1);
    issue_command(K_READ, 8'h00, 1'b0, 8'h5A, 1'b0);
    issue_command(K_READ, 8'h00, 1'b0, 8'h81, 1'b0);
  endtask

  task automatic test_ack_bits();
    issue_command(K_ACK, 8'h00, 1'b0, 8'h00, 1'b0);
    issue_command(K_ACK, 8'hFF, 1'b1, 8'hFF, 1'b1);
    issue_command(K_ACK, 8'h00, 1'b0, 8'h00, 1'b1);
    issue_command(K_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic test_unused_kinds();
    send_idle_tick(1'b1);
    send_idle_tick(1'b1);
    send_idle_tick(1'b1);
  endtask

  // mostly whole commands with random content, some idle and unused-kind ticks in between
  task automatic test_random_traffic(input int n_busy, input bit quiet);
    int goal;
    int pick;
    quiet_run = quiet;
    goal = busy_ticks + n_busy;
    while (busy_ticks < goal) begin
      pick = $urandom_range(99);
      if (pick < 80)
        issue_command(KIND_W'($urandom_range(K_START, K_ACK)), 8'($urandom), 1'($urandom),
                      8'($urandom), 1'($urandom));
      else
        send_idle_tick(pick >= 90);
    end
    quiet_run = 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= !quiet_run && ($urandom_range(99) < 6);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        $error("result with no transaction pending: %p", out_data);
        fails++;
      end else begin
        want = expected_lines.pop_front();
        if (out_data.scl_out !== want.scl_out) begin
          $error("scl_out: expected %0d, got %0d", want.scl_out, out_data.scl_out);
          fails++;
        end
        if (out_data.sda_out !== want.sda_out) begin
          $error("sda_out: expected %0d, got %0d", want.sda_out, out_data.sda_out);
          fails++;
        end
        if (out_data.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_data.busy_res);
          fails++;
        end
        if (out_data.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, out_data.done_res);
          fails++;
        end
        if (out_data.rx_byte !== want.rx_byte) begin
          $error("rx_byte: expected %02h, got %02h", want.rx_byte, out_data.rx_byte);
          fails++;
        end
        if (out_data.ack_seen !== want.ack_seen) begin
          $error("ack_seen: expected %0d, got %0d", want.ack_seen, out_data.ack_seen);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out with %0d results outstanding", expected_lines.size());
      $display("i2c_master_line_sequencer_tb: FAIL");
      $finish;
    end
  end

  initial begin
    fails      = 0;
    cycles     = 0;
    ticks_sent = 0;
    busy_ticks = 0;
    quiet_run  = 1'b0;
    foreach (cmds_taken[i]) cmds_taken[i] = 0;
    ln_phase = '0;
    ln_kind  = K_START;
    ln_busy  = 1'b0;
    ln_shift = '0;
    ln_scl   = 1'b1;
    ln_sda   = 1'b1;
    ln_ack   = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_after_reset();
    test_bus_conditions();
    test_byte_write();
    test_byte_read();
    test_ack_bits();
    test_unused_kinds();
    test_random_traffic(400, 1'b1);
    test_random_traffic(1600, 1'b0);

    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d ticks sent, %0d of them busy; all line results compared", ticks_sent,
             busy_ticks);
    $display("commands: start %0d, stop %0d, write %0d, read %0d, ack %0d",
             cmds_taken[K_START], cmds_taken[K_STOP], cmds_taken[K_WRITE],
             cmds_taken[K_READ], cmds_taken[K_ACK]);
    if (fails == 0) begin
      $display("i2c_master_line_sequencer_tb: PASS");
    end else begin
      $display("i2c_master_line_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
